// File: src/stpr_pkg.sv
// ----------------------------------------------------------------------------
// stpr_pkg
// Types, constants and helpers shared by the stepper ramp pulser.
// ----------------------------------------------------------------------------
`default_nettype none

package stpr_pkg;

  localparam int unsigned PosWidth    = 16;
  localparam int unsigned PeriodWidth = 8;
  localparam int unsigned BoundWidth  = PosWidth + 2;
  localparam int unsigned DiffWidth   = PeriodWidth + 2;
  localparam int unsigned CfgWidth    = PosWidth;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned InDataWidth = 16;
  localparam int unsigned OutDataWidth = 32;

  localparam logic [PeriodWidth-1:0] StopPeriod = PeriodWidth'(255);

  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    PH_ACCEL  = 2'd0,
    PH_CRUISE = 2'd1,
    PH_DECEL  = 2'd2
  } phase_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_START_PERIOD   = 2'd0,
    CFG_TARGET_PERIOD  = 2'd1,
    CFG_MOVE_REVERSE   = 2'd2,
    CFG_FINAL_POSITION = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [PeriodWidth-1:0]   start_period;
    logic [PeriodWidth-1:0]   target_period;
    logic                     move_reverse;
    logic signed [PosWidth-1:0] final_position;
  } cfg_t;

  typedef struct packed {
    logic signed [PosWidth-1:0]   position;
    logic signed [BoundWidth-1:0] accel_bound;
    logic signed [BoundWidth-1:0] decel_bound;
    logic [PeriodWidth-1:0]       period;
    logic [PeriodWidth-1:0]       tick_count;
    logic                         first_half;
    logic                         running;
    logic                         out_level;
  } ramp_state_t;

  typedef struct packed {
    logic                       step_level;
    logic signed [PosWidth-1:0] position_now;
    logic [PeriodWidth-1:0]     period_now;
    logic                       is_running;
    logic                       run_done;
    phase_e                     ramp_phase;
  } result_t;

  // Ramp phase of a position against the bounds, in the direction of travel.
  function automatic phase_e phase_of(input logic signed [PosWidth-1:0] pos,
                                      input logic signed [BoundWidth-1:0] acc,
                                      input logic signed [BoundWidth-1:0] dec,
                                      input logic rev);
    logic signed [BoundWidth-1:0] p;
    logic before_acc;
    logic before_dec;
    p = BoundWidth'(pos);
    before_acc = rev ? (p > acc) : (p < acc);
    before_dec = rev ? (p > dec) : (p < dec);
    if (before_acc) begin
      return PH_ACCEL;
    end else if (before_dec) begin
      return PH_CRUISE;
    end
    return PH_DECEL;
  endfunction

endpackage

`default_nettype wire

// File: src/stpr_core.sv
// ----------------------------------------------------------------------------
// stpr_core
// Next-state and result logic for one start or tick item.
// ----------------------------------------------------------------------------
`default_nettype none

module stpr_core (
  input  stpr_pkg::cfg_t                       cfg_i,
  input  stpr_pkg::ramp_state_t                state_i,
  input  stpr_pkg::op_e                        op_i,
  input  logic signed [stpr_pkg::PosWidth-1:0] start_pos_i,
  output stpr_pkg::ramp_state_t                state_o,
  output stpr_pkg::result_t                    result_o
);
  import stpr_pkg::*;

  logic                         rev;
  logic signed [DiffWidth-1:0]  diff;
  logic signed [DiffWidth-1:0]  sdiff;
  logic signed [PosWidth-1:0]   pos_step;
  phase_e                       step_phase;
  logic                         done;
  ramp_state_t                  nxt;

  assign rev  = cfg_i.move_reverse;
  assign diff = $signed(DiffWidth'({1'b0, cfg_i.start_period}))
              - $signed(DiffWidth'({1'b0, cfg_i.target_period}));
  assign sdiff = rev ? -diff : diff;
  assign pos_step = rev ? state_i.position - PosWidth'(1) : state_i.position + PosWidth'(1);
  assign step_phase = phase_of(pos_step, state_i.accel_bound, state_i.decel_bound, rev);

  always_comb begin
    nxt  = state_i;
    done = 1'b0;
    if (op_i == OP_START) begin
      nxt.position    = start_pos_i;
      nxt.accel_bound = BoundWidth'(start_pos_i) + BoundWidth'(sdiff);
      nxt.decel_bound = BoundWidth'(cfg_i.final_position) - BoundWidth'(sdiff);
      nxt.tick_count  = '0;
      nxt.period      = cfg_i.start_period;
      nxt.first_half  = 1'b1;
      nxt.out_level   = 1'b0;
      nxt.running     = 1'b1;
    end else if (state_i.running) begin
      if (state_i.tick_count == state_i.period) begin
        nxt.tick_count = '0;
        nxt.out_level  = ~state_i.out_level;
        if (state_i.first_half) begin
          nxt.position = pos_step;
          unique case (step_phase)
            PH_ACCEL: begin
              if (state_i.period > cfg_i.target_period) begin
                nxt.period = state_i.period - PeriodWidth'(1);
              end
            end
            PH_CRUISE: begin
              nxt.period = cfg_i.target_period;
            end
            default: begin
              if (state_i.period < cfg_i.start_period) begin
                nxt.period = state_i.period + PeriodWidth'(1);
              end
            end
          endcase
          if (pos_step == cfg_i.final_position) begin
            nxt.running    = 1'b0;
            nxt.out_level  = 1'b0;
            nxt.period     = StopPeriod;
            nxt.first_half = 1'b1;
            done           = 1'b1;
          end else begin
            nxt.first_half = 1'b0;
          end
        end else begin
          nxt.first_half = 1'b1;
        end
      end else begin
        nxt.tick_count = state_i.tick_count + PeriodWidth'(1);
      end
    end
  end

  assign state_o = nxt;

  always_comb begin
    result_o.step_level   = nxt.out_level;
    result_o.position_now = nxt.position;
    result_o.period_now   = nxt.period;
    result_o.is_running   = nxt.running;
    result_o.run_done     = done;
    result_o.ramp_phase   = nxt.running
                          ? phase_of(nxt.position, nxt.accel_bound, nxt.decel_bound, rev)
                          : PH_ACCEL;
  end

endmodule

`default_nettype wire

// File: src/stepper_trapezoid_ramp_pulser_unit.sv
// ----------------------------------------------------------------------------
// stepper_trapezoid_ramp_pulser_unit
// Step-pulse generator with a trapezoidal speed ramp, stream in / stream out.
// ----------------------------------------------------------------------------
//  port group   dir  payload
//  s_axis_*     in   tdata: start_position[15:0]; tuser: operation
//  m_axis_*     out  tdata: step_level, position_now, period_now, is_running,
//                    ramp_phase; tlast: run_done
//  cfg_*        in   write enable, register index, write data
//
//  One item per cycle unless a result stall holds the input: start and tick
//  are both worked out in one pass of stpr_core, between the state registers
//  and the result register; results are valid in the cycle after the input.
//  Reset: config 255/255/0/0, ramp stopped, period 255, no result pending.
//  A stalled result blocks input only while the result register is full
//  and the sink is not ready.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_trapezoid_ramp_pulser_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [15:0] start_position
  input  logic [stpr_pkg::InDataWidth-1:0]     s_axis_tdata_i,
  // [0] operation
  input  logic                                 s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // [0] step_level, [16:1] position_now, [24:17] period_now,
  // [25] is_running, [27:26] ramp_phase, [31:28] zero
  output logic [stpr_pkg::OutDataWidth-1:0]    m_axis_tdata_o,
  output logic                                 m_axis_tlast_o,
  input  logic                                 cfg_we_i,
  input  logic [stpr_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  logic [stpr_pkg::CfgWidth-1:0]        cfg_data_i
);
  import stpr_pkg::*;

  cfg_t        cfg_q;
  ramp_state_t state_q, state_d;
  result_t     res_q, res_d;
  logic        out_valid_q;
  logic        in_xfer;

  assign s_axis_tready_o = ~out_valid_q | m_axis_tready_i;
  assign in_xfer = s_axis_tvalid_i & s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_period   <= StopPeriod;
      cfg_q.target_period  <= StopPeriod;
      cfg_q.move_reverse   <= 1'b0;
      cfg_q.final_position <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_START_PERIOD:   cfg_q.start_period   <= cfg_data_i[PeriodWidth-1:0];
        CFG_TARGET_PERIOD:  cfg_q.target_period  <= cfg_data_i[PeriodWidth-1:0];
        CFG_MOVE_REVERSE:   cfg_q.move_reverse   <= cfg_data_i[0];
        CFG_FINAL_POSITION: cfg_q.final_position <= cfg_data_i[PosWidth-1:0];
        default: ;
      endcase
    end
  end

  stpr_core u_core (
    .cfg_i       (cfg_q),
    .state_i     (state_q),
    .op_i        (op_e'(s_axis_tuser_i)),
    .start_pos_i (s_axis_tdata_i[PosWidth-1:0]),
    .state_o     (state_d),
    .result_o    (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.position    <= '0;
      state_q.accel_bound <= '0;
      state_q.decel_bound <= '0;
      state_q.period      <= StopPeriod;
      state_q.tick_count  <= '0;
      state_q.first_half  <= 1'b1;
      state_q.running     <= 1'b0;
      state_q.out_level   <= 1'b0;
      out_valid_q         <= 1'b0;
    end else begin
      if (in_xfer) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = res_q.run_done;
  assign m_axis_tdata_o  = {4'b0000, res_q.ramp_phase, res_q.is_running, res_q.period_now,
                            res_q.position_now, res_q.step_level};

  // Stopped ramp always sits with a cleared counter and a low output.
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.running |-> (state_q.tick_count == '0) && !state_q.out_level
                         && state_q.first_half)
    else $error("idle ramp state not clean");

  // A finished run shows as stopped with the stop period.
  a_done_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> !res_q.is_running && !res_q.step_level
                                          && (res_q.period_now == StopPeriod))
    else $error("run_done with ramp still active");

  // A held result blocks the input side.
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input taken while result stalled");

  // Every input transfer yields a pending result on the next cycle.
  a_xfer_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> m_axis_tvalid_o)
    else $error("result lost after input transfer");

endmodule

`default_nettype wire
